>>> src/plist_pkg.sv
// positional list store: shared payload types, field widths and codes
// no dependencies; used by positional_list_store_top
`default_nettype none

package plist_pkg;

    // fixed field widths of the transfer payloads
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_POS   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DEL_BACK  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DEL_POS   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OOB   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0]        element_count;
    } out_item_t;

endpackage

`default_nettype wire

>>> src/positional_list_store_top.sv
// positional list store: bounded singly linked list of signed 32-bit values
// kept in a node value memory and a node link memory with a free list
// depends on plist_pkg
//
// usage
//   one request transfer on s_* (action, value, position) gives exactly one
//   result transfer on m_* (status, removed value, element count after the
//   action). requests are handled one at a time, in order.
// walk
//   front insert or delete needs no walk. insert or delete at index k >= 1
//   (back means k = count or count - 1) walks the link chain to the node
//   before index k, one node per cycle through the single read port of the
//   link memory; reuse of a freed slot adds the alloc step, and a delete
//   adds its unlink and free steps. rejected requests (out of range, empty,
//   full) go straight to the result state.
// throughput
//   one request in flight; s_ready is high whenever the sequencer is idle,
//   also while a finished result still waits in the output register.
// reset
//   aresetn (synchronous, active low) empties the list and the free list at
//   once; the node memories are not cleared, slots are written before use.
// stalls
//   if m_ready is low the result holds in the output register; a following
//   request is still taken and processed, and waits only at its hand-off.
`default_nettype none

module positional_list_store_top #(
    parameter int CAPACITY = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire plist_pkg::in_item_t  s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output plist_pkg::out_item_t      m_item
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int POS_W   = plist_pkg::POS_W;
    localparam int COUNT_W = plist_pkg::COUNT_W;
    localparam int VALUE_W = plist_pkg::VALUE_W;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SUM_W   = CNT_W + 1;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [9:0] {
        ST_IDLE       = 10'b0000000001,
        ST_ALLOC      = 10'b0000000010,
        ST_WALK       = 10'b0000000100,
        ST_INS_SPLICE = 10'b0000001000,
        ST_INS_LINK   = 10'b0000010000,
        ST_DEL_HEAD   = 10'b0000100000,
        ST_DEL_FETCH  = 10'b0001000000,
        ST_DEL_UNLINK = 10'b0010000000,
        ST_DEL_FREE   = 10'b0100000000,
        ST_RESP       = 10'b1000000000
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [SLOT_W-1:0]   free_head_reg, free_head_next;
    logic [CNT_W-1:0]    free_len_reg, free_len_next;
    logic [CNT_W-1:0]    fresh_reg, fresh_next;
    logic                m_valid_reg, m_valid_next;

    // per-request working registers
    logic                is_ins_reg, is_ins_next;
    logic                pos_zero_reg, pos_zero_next;
    logic                walk_first_reg, walk_first_next;
    logic [CMP_W-1:0]    steps_reg, steps_next;
    logic [SLOT_W-1:0]   new_slot_reg, new_slot_next;
    logic [SLOT_W-1:0]   pred_reg, pred_next;
    logic [SLOT_W-1:0]   victim_reg, victim_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [plist_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic signed [VALUE_W-1:0] res_removed_reg, res_removed_next;
    plist_pkg::out_item_t m_item_reg, m_item_next;

    // node memories and their registered read data
    logic [SLOT_W-1:0]         node_links_mem [CAPACITY];
    logic signed [VALUE_W-1:0] node_values_mem [CAPACITY];
    logic [SLOT_W-1:0]         link_rdata_reg;
    logic signed [VALUE_W-1:0] value_rdata_reg;

    logic                      link_re, link_we, val_re, val_we;
    logic [SLOT_W-1:0]         link_raddr, link_waddr, link_wdata;
    logic [SLOT_W-1:0]         val_raddr, val_waddr;
    logic signed [VALUE_W-1:0] val_wdata;

    // request decode
    logic [CMP_W-1:0]    len_ext, pos_ext, eff_pos;
    logic                req_ins, req_err, store_full;
    logic [plist_pkg::STATUS_W-1:0] err_status;
    logic [SLOT_W-1:0]   walk_cur;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign len_ext    = CMP_W'(len_reg);
    assign pos_ext    = CMP_W'(s_item.position);
    assign store_full = (free_len_reg == '0) && (fresh_reg == CAP_C);
    assign walk_cur   = walk_first_reg ? head_reg : link_rdata_reg;

    // effective index and early rejection of a request
    always_comb begin
        eff_pos    = '0;
        req_ins    = 1'b0;
        req_err    = 1'b0;
        err_status = plist_pkg::STAT_OK;
        unique case (s_item.action)
            plist_pkg::ACT_INS_FRONT,
            plist_pkg::ACT_INS_BACK,
            plist_pkg::ACT_INS_POS: begin
                req_ins = 1'b1;
                if (s_item.action == plist_pkg::ACT_INS_BACK) begin
                    eff_pos = len_ext;
                end else if (s_item.action == plist_pkg::ACT_INS_POS) begin
                    eff_pos = pos_ext;
                end
                if (eff_pos > len_ext) begin
                    req_err    = 1'b1;
                    err_status = plist_pkg::STAT_OOB;
                end else if (store_full) begin
                    req_err    = 1'b1;
                    err_status = plist_pkg::STAT_FULL;
                end
            end
            plist_pkg::ACT_DEL_FRONT,
            plist_pkg::ACT_DEL_BACK: begin
                if (s_item.action == plist_pkg::ACT_DEL_BACK) begin
                    eff_pos = len_ext - CMP_W'(1);
                end
                if (len_reg == '0) begin
                    req_err    = 1'b1;
                    err_status = plist_pkg::STAT_EMPTY;
                end
            end
            plist_pkg::ACT_DEL_POS: begin
                eff_pos = pos_ext;
                if (eff_pos >= len_ext) begin
                    req_err    = 1'b1;
                    err_status = plist_pkg::STAT_OOB;
                end
            end
            default: begin
                req_err    = 1'b1;
                err_status = plist_pkg::STAT_OOB;
            end
        endcase
    end

    // sequencer: allocate, walk the chain, splice or unlink and free, hand off
    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        len_next         = len_reg;
        free_head_next   = free_head_reg;
        free_len_next    = free_len_reg;
        fresh_next       = fresh_reg;
        m_valid_next     = m_valid_reg;
        is_ins_next      = is_ins_reg;
        pos_zero_next    = pos_zero_reg;
        walk_first_next  = walk_first_reg;
        steps_next       = steps_reg;
        new_slot_next    = new_slot_reg;
        pred_next        = pred_reg;
        victim_next      = victim_reg;
        value_next       = value_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        m_item_next      = m_item_reg;
        link_re          = 1'b0;
        link_raddr       = '0;
        link_we          = 1'b0;
        link_waddr       = '0;
        link_wdata       = '0;
        val_re           = 1'b0;
        val_raddr        = '0;
        val_we           = 1'b0;
        val_waddr        = '0;
        val_wdata        = '0;

        // result register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    is_ins_next      = req_ins;
                    pos_zero_next    = (eff_pos == '0);
                    steps_next       = eff_pos - CMP_W'(1);
                    walk_first_next  = 1'b1;
                    value_next       = s_item.value;
                    res_removed_next = '0;
                    if (req_err) begin
                        res_status_next = err_status;
                        state_next      = ST_RESP;
                    end else if (req_ins && free_len_reg != '0) begin
                        // reuse the most recently freed slot
                        new_slot_next = free_head_reg;
                        free_len_next = free_len_reg - CNT_W'(1);
                        link_re       = 1'b1;
                        link_raddr    = free_head_reg;
                        state_next    = ST_ALLOC;
                    end else if (req_ins) begin
                        // take the next never-used slot
                        new_slot_next = fresh_reg[SLOT_W-1:0];
                        fresh_next    = fresh_reg + CNT_W'(1);
                        state_next    = ST_WALK;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_ALLOC: begin
                free_head_next = link_rdata_reg;
                state_next     = ST_WALK;
            end
            ST_WALK: begin
                walk_first_next = 1'b0;
                if (pos_zero_reg && is_ins_reg) begin
                    // new node becomes the head
                    link_we         = 1'b1;
                    link_waddr      = new_slot_reg;
                    link_wdata      = head_reg;
                    val_we          = 1'b1;
                    val_waddr       = new_slot_reg;
                    val_wdata       = value_reg;
                    head_next       = new_slot_reg;
                    len_next        = len_reg + CNT_W'(1);
                    res_status_next = plist_pkg::STAT_OK;
                    state_next      = ST_RESP;
                end else if (pos_zero_reg) begin
                    // head is the victim: fetch its link and value
                    victim_next = head_reg;
                    link_re     = 1'b1;
                    link_raddr  = head_reg;
                    val_re      = 1'b1;
                    val_raddr   = head_reg;
                    state_next  = ST_DEL_HEAD;
                end else if (steps_reg == '0) begin
                    // predecessor reached: fetch its successor
                    pred_next  = walk_cur;
                    link_re    = 1'b1;
                    link_raddr = walk_cur;
                    state_next = is_ins_reg ? ST_INS_SPLICE : ST_DEL_FETCH;
                end else begin
                    // one node further down the chain
                    link_re    = 1'b1;
                    link_raddr = walk_cur;
                    steps_next = steps_reg - CMP_W'(1);
                end
            end
            ST_INS_SPLICE: begin
                link_we    = 1'b1;
                link_waddr = new_slot_reg;
                link_wdata = link_rdata_reg;
                state_next = ST_INS_LINK;
            end
            ST_INS_LINK: begin
                link_we         = 1'b1;
                link_waddr      = pred_reg;
                link_wdata      = new_slot_reg;
                val_we          = 1'b1;
                val_waddr       = new_slot_reg;
                val_wdata       = value_reg;
                len_next        = len_reg + CNT_W'(1);
                res_status_next = plist_pkg::STAT_OK;
                state_next      = ST_RESP;
            end
            ST_DEL_HEAD: begin
                head_next        = link_rdata_reg;
                res_removed_next = value_rdata_reg;
                state_next       = ST_DEL_FREE;
            end
            ST_DEL_FETCH: begin
                victim_next = link_rdata_reg;
                link_re     = 1'b1;
                link_raddr  = link_rdata_reg;
                val_re      = 1'b1;
                val_raddr   = link_rdata_reg;
                state_next  = ST_DEL_UNLINK;
            end
            ST_DEL_UNLINK: begin
                link_we          = 1'b1;
                link_waddr       = pred_reg;
                link_wdata       = link_rdata_reg;
                res_removed_next = value_rdata_reg;
                state_next       = ST_DEL_FREE;
            end
            ST_DEL_FREE: begin
                // push the victim onto the free list
                link_we         = 1'b1;
                link_waddr      = victim_reg;
                link_wdata      = free_head_reg;
                free_head_next  = victim_reg;
                free_len_next   = free_len_reg + CNT_W'(1);
                len_next        = len_reg - CNT_W'(1);
                res_status_next = plist_pkg::STAT_OK;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                // hand off once the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_item_next.status        = res_status_reg;
                    m_item_next.removed_value = res_removed_reg;
                    m_item_next.element_count = COUNT_W'(len_reg);
                    m_valid_next              = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            len_reg       <= '0;
            free_head_reg <= '0;
            free_len_reg  <= '0;
            fresh_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            free_head_reg <= free_head_next;
            free_len_reg  <= free_len_next;
            fresh_reg     <= fresh_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        is_ins_reg      <= is_ins_next;
        pos_zero_reg    <= pos_zero_next;
        walk_first_reg  <= walk_first_next;
        steps_reg       <= steps_next;
        new_slot_reg    <= new_slot_next;
        pred_reg        <= pred_next;
        victim_reg      <= victim_next;
        value_reg       <= value_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        m_item_reg      <= m_item_next;
    end

    // link memory; each access is sequenced so no read meets a pending write
    always_ff @(posedge aclk) begin
        if (link_we) begin
            node_links_mem[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            link_rdata_reg <= node_links_mem[link_raddr];
        end
    end

    // value memory
    always_ff @(posedge aclk) begin
        if (val_we) begin
            node_values_mem[val_waddr] <= val_wdata;
        end
        if (val_re) begin
            value_rdata_reg <= node_values_mem[val_raddr];
        end
    end

    // list never grows beyond the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg <= CAP_C) && (fresh_reg <= CAP_C))
        else $error("list length or fresh slot count beyond capacity");

    // between requests every slot handed out is in the list or on the free list
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE)
        |-> ((SUM_W'(len_reg) + SUM_W'(free_len_reg)) == SUM_W'(fresh_reg)))
        else $error("slot accounting lost a node");

    // sequencer state stays one-hot
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // a hand-off always loads the result register and frees the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP) && (!m_valid_reg || m_ready)
        |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("result hand-off did not complete");

endmodule

`default_nettype wire
